// ----- rtl/core/ttcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types, widths and constants for the lidar time-to-collision brake.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

   // default sizes of the scan and of the cosine table
   localparam int NumBeamsDefault     = 1080;
   localparam int CenterBeamDefault   = 540;
   localparam int CosTableDepthDefault = 1024;

   // field widths
   localparam int SpeedW     = 16;
   localparam int RangeW     = 16;
   localparam int ThrW       = 12;
   localparam int StepW      = 16;
   localparam int BeamIdxW   = 11;
   localparam int ClosingW   = 15;
   localparam int DiffW      = 11;
   localparam int CosW       = 16;
   localparam int CsrDataW   = 32;
   localparam int CsrAddrW   = 3;

   // register reset values
   localparam logic [ThrW-1:0]  ThrReset  = 12'd250;
   localparam logic [StepW-1:0] StepReset = 16'd286;

   // register indexes, taken from paddr[2]
   localparam logic CsrIdxThr  = 1'b0;
   localparam logic CsrIdxStep = 1'b1;

   // range code for a beam without a return
   localparam logic [RangeW-1:0] NoReturn = 16'hFFFF;

   // angles in Q16 radians
   localparam longint TwoPiQ16  = 411775;
   localparam longint PiQ16     = 205887;
   localparam longint HalfPiQ16 = 102944;
   localparam int     AngW      = $clog2(TwoPiQ16);

   // x / 2pi by reciprocal: floor(x * RecipMult / 2^RecipShift) is the
   // quotient or one below it for any x under 2^RecipShift
   localparam int     RecipShift = 32;
   localparam longint RecipMult  = (64'd1 << RecipShift) / TwoPiQ16;
   localparam int     RecipW     = $clog2(RecipMult + 1);

   // range in mm is scaled to match ms * mm/s
   localparam int RangeScale = 1000;

   // front to back queue
   localparam int QueueDepth = 4;

   typedef struct packed {
      logic signed [SpeedW-1:0] speed_mm_s;
      logic [RangeW-1:0]        range_mm;
      logic                     last_beam;
   } req_type;

   typedef struct packed {
      logic [BeamIdxW-1:0] beam_index;
      logic [ClosingW-1:0] closing_speed;
   } rsp_type;

   // one classified beam, as queued between front and back
   typedef struct packed {
      logic [BeamIdxW-1:0]      beam_index;
      logic [DiffW-1:0]         diff;
      logic signed [SpeedW-1:0] speed;
      logic [RangeW-1:0]        range;
      logic                     last;
      logic                     cand;
   } beam_type;

endpackage

`default_nettype wire

// ----- rtl/core/ttcb_front.sv -----
// ----------------------------------------------------------------------------
// ttcb_front
// Accepts beams, numbers them within the scan and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_front #(
   parameter int NUM_BEAMS   = ttcb_pkg::NumBeamsDefault,
   parameter int CENTER_BEAM = ttcb_pkg::CenterBeamDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ttcb_pkg::req_type req_data,
   input  wire logic              q_full,
   output logic                   q_push,
   output ttcb_pkg::beam_type     q_push_data
);

   localparam int CntW = $clog2(NUM_BEAMS + 1);
   localparam int CmpW = 12;

   logic [CntW-1:0] counter_ff;
   logic [CntW-1:0] counter_in;
   logic            in_scan;
   logic [CmpW-1:0] cnt_ext;
   logic [CmpW-1:0] center_ext;
   logic [CmpW-1:0] diff_full;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign in_scan    = counter_ff < CntW'(NUM_BEAMS);
   assign cnt_ext    = CmpW'(counter_ff);
   assign center_ext = CmpW'(CENTER_BEAM);
   assign diff_full  = (cnt_ext >= center_ext) ? (cnt_ext - center_ext)
                                                : (center_ext - cnt_ext);

   always_comb begin
      q_push_data.beam_index = ttcb_pkg::BeamIdxW'(counter_ff);
      q_push_data.diff       = diff_full[ttcb_pkg::DiffW-1:0];
      q_push_data.speed      = req_data.speed_mm_s;
      q_push_data.range      = req_data.range_mm;
      q_push_data.last       = req_data.last_beam;
      q_push_data.cand       = in_scan && (req_data.range_mm != '0) &&
                               (req_data.range_mm != ttcb_pkg::NoReturn);
   end

   // counter saturates at the scan length until the last beam
   always_comb begin
      counter_in = counter_ff;
      if (q_push) begin
         if (req_data.last_beam) begin
            counter_in = '0;
         end else if (in_scan) begin
            counter_in = counter_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ttcb_queue.sv -----
// ----------------------------------------------------------------------------
// ttcb_queue
// Short FIFO of classified beams between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ttcb_pkg::beam_type push_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output ttcb_pkg::beam_type      head
);

   localparam int PtrW = $clog2(ttcb_pkg::QueueDepth);
   localparam int CntW = $clog2(ttcb_pkg::QueueDepth + 1);

   ttcb_pkg::beam_type entry_ff [ttcb_pkg::QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff;
   logic [PtrW-1:0]    rd_ptr_ff;
   logic [CntW-1:0]    count_ff;

   assign full  = count_ff == CntW'(ttcb_pkg::QueueDepth);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ttcb_back.sv -----
// ----------------------------------------------------------------------------
// ttcb_back
// Angle, cosine projection and TTC compare pipeline; emits brake events.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_back #(
   parameter int COS_TABLE_DEPTH = ttcb_pkg::CosTableDepthDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ttcb_pkg::ThrW-1:0]     cfg_thr,
   input  wire logic [ttcb_pkg::StepW-1:0]    cfg_step,
   input  wire logic                          q_empty,
   input  wire ttcb_pkg::beam_type            q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ttcb_pkg::rsp_type                  rsp_data
);

   localparam int AngW    = ttcb_pkg::AngW;
   localparam int RemW    = AngW + 1;
   localparam int ProdW   = ttcb_pkg::DiffW + ttcb_pkg::StepW;
   localparam int Mq1W    = ProdW + ttcb_pkg::RecipW;
   localparam int Q1W     = Mq1W - ttcb_pkg::RecipShift;
   localparam int DepthW  = $clog2(COS_TABLE_DEPTH);
   localparam int DepthVW = $clog2(COS_TABLE_DEPTH + 1);
   localparam int X2W     = AngW + DepthVW;
   localparam int Mq2W    = X2W + ttcb_pkg::RecipW;
   localparam int Q2W     = Mq2W - ttcb_pkg::RecipShift;
   localparam int LhsW    = ttcb_pkg::RangeW + $clog2(ttcb_pkg::RangeScale + 1);
   localparam int PW      = 2 * ttcb_pkg::CosW;
   localparam int ProjW   = ttcb_pkg::ClosingW;
   localparam int RhsW    = ttcb_pkg::ThrW + ProjW;
   localparam int Stages  = 11;
   localparam int LastSt  = Stages - 1;

   typedef struct packed {
      logic [ttcb_pkg::BeamIdxW-1:0]      beam_index;
      logic signed [ttcb_pkg::SpeedW-1:0] speed;
      logic [ttcb_pkg::RangeW-1:0]        range;
      logic                               last;
      logic                               cand;
      logic [ProdW-1:0]                   prod;
      logic [Q1W-1:0]                     q1;
      logic [RemW-1:0]                    r1;
      logic [AngW-1:0]                    ang;
      logic [LhsW-1:0]                    lhs;
      logic [X2W-1:0]                     x2;
      logic [Q2W-1:0]                     q2;
      logic [RemW-1:0]                    r2;
      logic [DepthW-1:0]                  idx;
      logic signed [ttcb_pkg::CosW-1:0]   cosv;
      logic signed [PW-1:0]               p;
      logic [ProjW-1:0]                   proj;
      logic                               pos;
      logic [RhsW-1:0]                    rhs;
   } pipe_type;

   // cosine table, built at elaboration: angle folded into the first
   // quadrant, nine-term Taylor series in Q28, rounded to Q15
   logic signed [ttcb_pkg::CosW-1:0] cos_tab [COS_TABLE_DEPTH];

   for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_cos
      localparam longint Theta = (longint'(k) * ttcb_pkg::TwoPiQ16) / COS_TABLE_DEPTH;
      localparam longint Fold  = (Theta > ttcb_pkg::PiQ16) ? ttcb_pkg::TwoPiQ16 - Theta
                                                           : Theta;
      localparam bit     Neg   = Fold > ttcb_pkg::HalfPiQ16;
      localparam longint Th    = Neg ? ttcb_pkg::PiQ16 - Fold : Fold;
      localparam longint One   = 64'sd268435456;
      localparam longint X     = Th * 4096;
      localparam longint X2    = (X * X) / One;
      localparam longint T1    = (One * X2) / One / 2;
      localparam longint T2    = (T1 * X2) / One / 12;
      localparam longint T3    = (T2 * X2) / One / 30;
      localparam longint T4    = (T3 * X2) / One / 56;
      localparam longint T5    = (T4 * X2) / One / 90;
      localparam longint T6    = (T5 * X2) / One / 132;
      localparam longint T7    = (T6 * X2) / One / 182;
      localparam longint T8    = (T7 * X2) / One / 240;
      localparam longint Sum   = One - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8;
      localparam longint SumC  = (Sum < 0) ? 0 : Sum;
      localparam longint Q     = (SumC + 4096) / 8192;
      localparam longint QC    = (Q > 32767) ? 32767 : Q;
      localparam logic signed [ttcb_pkg::CosW-1:0] CosVal =
         Neg ? ttcb_pkg::CosW'(-QC) : ttcb_pkg::CosW'(QC);
      assign cos_tab[k] = CosVal;
   end

   pipe_type pipe_ff [Stages];
   pipe_type pipe_in [Stages];
   logic     vld_ff  [Stages];
   logic     adv;
   logic     hit;
   logic     emit;
   logic     fired_ff;
   logic     fired_in;
   logic     rsp_valid_ff;
   ttcb_pkg::rsp_type rsp_data_ff;

   logic [Mq1W-1:0]  mq1;
   logic [ProdW-1:0] qp1;
   logic [ProdW-1:0] r1_full;
   logic [Mq2W-1:0]  mq2;
   logic [X2W-1:0]   qp2;
   logic [X2W-1:0]   r2_full;
   logic [Q2W-1:0]   idx_full;

   // whole pipeline moves unless a finished event waits at the output
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_empty;

   assign mq1      = Mq1W'(pipe_ff[0].prod) * Mq1W'(ttcb_pkg::RecipMult);
   assign qp1      = ProdW'(pipe_ff[1].q1) * ProdW'(ttcb_pkg::TwoPiQ16);
   assign r1_full  = pipe_ff[1].prod - qp1;
   assign mq2      = Mq2W'(pipe_ff[4].x2) * Mq2W'(ttcb_pkg::RecipMult);
   assign qp2      = X2W'(pipe_ff[5].q2) * X2W'(ttcb_pkg::TwoPiQ16);
   assign r2_full  = pipe_ff[5].x2 - qp2;
   assign idx_full = pipe_ff[6].q2 +
                     Q2W'(pipe_ff[6].r2 >= RemW'(ttcb_pkg::TwoPiQ16));

   always_comb begin
      pipe_in[0]            = '0;
      pipe_in[0].beam_index = q_head.beam_index;
      pipe_in[0].speed      = q_head.speed;
      pipe_in[0].range      = q_head.range;
      pipe_in[0].last       = q_head.last;
      pipe_in[0].cand       = q_head.cand;
      pipe_in[0].prod       = ProdW'(q_head.diff) * ProdW'(cfg_step);

      // quotient estimate of prod / 2pi
      pipe_in[1]    = pipe_ff[0];
      pipe_in[1].q1 = mq1[Mq1W-1:ttcb_pkg::RecipShift];

      pipe_in[2]    = pipe_ff[1];
      pipe_in[2].r1 = r1_full[RemW-1:0];

      // remainder correction gives the angle mod 2pi
      pipe_in[3]     = pipe_ff[2];
      pipe_in[3].ang = (pipe_ff[2].r1 >= RemW'(ttcb_pkg::TwoPiQ16))
                       ? AngW'(pipe_ff[2].r1 - RemW'(ttcb_pkg::TwoPiQ16))
                       : AngW'(pipe_ff[2].r1);
      pipe_in[3].lhs = LhsW'(pipe_ff[2].range) * LhsW'(ttcb_pkg::RangeScale);

      pipe_in[4]    = pipe_ff[3];
      pipe_in[4].x2 = X2W'(pipe_ff[3].ang) * X2W'(COS_TABLE_DEPTH);

      // table index = ang * depth / 2pi
      pipe_in[5]    = pipe_ff[4];
      pipe_in[5].q2 = mq2[Mq2W-1:ttcb_pkg::RecipShift];

      pipe_in[6]    = pipe_ff[5];
      pipe_in[6].r2 = r2_full[RemW-1:0];

      pipe_in[7]     = pipe_ff[6];
      pipe_in[7].idx = idx_full[DepthW-1:0];

      pipe_in[8]      = pipe_ff[7];
      pipe_in[8].cosv = cos_tab[pipe_ff[7].idx];

      pipe_in[9]   = pipe_ff[8];
      pipe_in[9].p = pipe_ff[8].speed * pipe_ff[8].cosv;

      // projected speed is p >> 15, positive products stay under 2^30
      pipe_in[10]      = pipe_ff[9];
      pipe_in[10].proj = pipe_ff[9].p[ProjW+14:15];
      pipe_in[10].pos  = !pipe_ff[9].p[PW-1] && (pipe_ff[9].p[ProjW+14:15] != '0);
      pipe_in[10].rhs  = RhsW'(cfg_thr) * RhsW'(pipe_ff[9].p[ProjW+14:15]);
   end

   assign hit  = pipe_ff[LastSt].cand && pipe_ff[LastSt].pos &&
                 (RhsW'(pipe_ff[LastSt].lhs) < pipe_ff[LastSt].rhs);
   assign emit = adv && vld_ff[LastSt] && hit && !fired_ff;

   // one event per scan; the last beam re-arms after its own test
   always_comb begin
      fired_in = fired_ff;
      if (adv && vld_ff[LastSt]) begin
         fired_in = pipe_ff[LastSt].last ? 1'b0 : (fired_ff || emit);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < Stages; s++) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
      if (emit) begin
         rsp_data_ff.beam_index    <= pipe_ff[LastSt].beam_index;
         rsp_data_ff.closing_speed <= pipe_ff[LastSt].proj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) begin
            vld_ff[s] <= 1'b0;
         end
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff[0] <= !q_empty;
            for (int s = 1; s < Stages; s++) begin
               vld_ff[s] <= vld_ff[s-1];
            end
            rsp_valid_ff <= emit;
         end
         fired_ff <= fired_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lidar_time_to_collision_brake_core.sv -----
// ----------------------------------------------------------------------------
// lidar_time_to_collision_brake_core
// Throughput: one beam per cycle while rsp is not stalled, set by the
// 11-stage back pipeline; the 4-beat queue lets the front keep taking
// beams while an event is stalled.
// Reset (synchronous): beam counter, brake flag, queue and pipeline clear;
// threshold returns to 250 ms and angle step to 286. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_time_to_collision_brake_core #(
   parameter int NUM_BEAMS       = ttcb_pkg::NumBeamsDefault,
   parameter int CENTER_BEAM     = ttcb_pkg::CenterBeamDefault,
   parameter int COS_TABLE_DEPTH = ttcb_pkg::CosTableDepthDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // beam input
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire ttcb_pkg::req_type               req_data,

   // brake events
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output ttcb_pkg::rsp_type                    rsp_data,

   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ttcb_pkg::CsrAddrW-1:0]   csr_paddr,
   input  wire logic [ttcb_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [ttcb_pkg::CsrDataW-1:0]        csr_prdata,
   output logic                                 csr_pready
);

   // ---------------------------------------------------------------------
   // Registers: threshold at 0x0, angle step at 0x4. Writes complete in
   // the access phase; the port never inserts wait states.
   // ---------------------------------------------------------------------
   logic [ttcb_pkg::ThrW-1:0]  thr_ff;
   logic [ttcb_pkg::StepW-1:0] step_ff;
   logic                       csr_wr;
   logic                       csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= ttcb_pkg::ThrReset;
         step_ff <= ttcb_pkg::StepReset;
      end else if (csr_wr) begin
         if (csr_idx == ttcb_pkg::CsrIdxThr) begin
            thr_ff <= csr_pwdata[ttcb_pkg::ThrW-1:0];
         end else begin
            step_ff <= csr_pwdata[ttcb_pkg::StepW-1:0];
         end
      end
   end

   always_comb begin
      if (csr_idx == ttcb_pkg::CsrIdxThr) begin
         csr_prdata = ttcb_pkg::CsrDataW'(thr_ff);
      end else begin
         csr_prdata = ttcb_pkg::CsrDataW'(step_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Front: numbers each beam in its scan, works out |index - center| and
   // flags beams worth testing (in scan, real nonzero range).
   // ---------------------------------------------------------------------
   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   ttcb_pkg::beam_type q_push_data;
   ttcb_pkg::beam_type q_head;

   ttcb_front #(
      .NUM_BEAMS   (NUM_BEAMS),
      .CENTER_BEAM (CENTER_BEAM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // ---------------------------------------------------------------------
   // Queue: decouples the beam stream from output backpressure.
   // ---------------------------------------------------------------------
   ttcb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // ---------------------------------------------------------------------
   // Back: angle mod 2pi and table index by reciprocal multiply, cosine
   // lookup, speed projection, then range*1000 < threshold*speed. Only the
   // first hit of a scan is sent; the last beam, tested or not, carries the
   // scan end marker that re-arms the brake.
   // ---------------------------------------------------------------------
   ttcb_back #(
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_thr   (thr_ff),
      .cfg_step  (step_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/ttcb_checker.sv -----
// ----------------------------------------------------------------------------
// ttcb_checker
// Port-level checks for the brake core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_checker #(
   parameter int NUM_BEAMS = ttcb_pkg::NumBeamsDefault
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire ttcb_pkg::rsp_type             rsp_data,
   input wire logic                          csr_psel,
   input wire logic                          csr_penable,
   input wire logic                          csr_pwrite,
   input wire logic [ttcb_pkg::CsrAddrW-1:0] csr_paddr,
   input wire logic [ttcb_pkg::CsrDataW-1:0] csr_pwdata,
   input wire logic [ttcb_pkg::CsrDataW-1:0] csr_prdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("event dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("event payload changed while stalled");

   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.closing_speed != '0) &&
                    (int'(rsp_data.beam_index) < NUM_BEAMS))
      else $error("brake event with zero speed or beam outside scan");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("event present right after reset");

   a_thr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && !csr_paddr[2] ##1
      csr_psel && !csr_pwrite && !csr_paddr[2]
      |-> csr_prdata[ttcb_pkg::ThrW-1:0] == $past(csr_pwdata[ttcb_pkg::ThrW-1:0]))
      else $error("threshold readback mismatch");

endmodule

bind lidar_time_to_collision_brake_core ttcb_checker #(
   .NUM_BEAMS (NUM_BEAMS)
) u_ttcb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire

// ----- bench/lidar_time_to_collision_brake_core_test.sv -----
// ----------------------------------------------------------------------------
// lidar_time_to_collision_brake_core_test
// Self-checking bench for the lidar time-to-collision brake core: beams go
// in on req, a local model of the scan counter, cosine projection and TTC
// compare predicts each brake event, and every rsp beat is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_time_to_collision_brake_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ttcb_pkg::*;

   localparam int ThrMax      = (1 << ThrW) - 1;
   localparam int StepMax     = (1 << StepW) - 1;
   localparam int DrainCycles = 48;   // well past the event path through queue, pipeline and output register

   // register map: index in paddr[2], word aligned
   localparam logic [CsrAddrW-1:0] ThrAddr  = {CsrIdxThr, 2'b00};
   localparam logic [CsrAddrW-1:0] StepAddr = {CsrIdxStep, 2'b00};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   // local copy of the block's state and registers
   int      brake_thr_ms;
   int      beam_step_q16;
   int      scan_beam;
   bit      scan_braked;
   int      cos_lut [CosTableDepthDefault];

   rsp_type brake_expect [$];   // predicted brake events, oldest first
   int      mismatches;

   // idle knobs: sender gaps, receiver stalls, one-shot long receiver hold
   bit      req_idle_on;
   bit      rsp_idle_on;
   int      long_hold;

   lidar_time_to_collision_brake_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // cos(angle) in Q15, angle in Q16 radians over one turn; Taylor series in
   // Q28 on the angle folded into the first quadrant
   function automatic int cosine_q15(input longint angle);
      longint a;
      longint x;
      longint x2;
      longint term;
      longint acc;
      longint q;
      bit     flip;
      int     n;
      a    = angle;
      flip = 1'b0;
      if (a > PiQ16) begin
         a = TwoPiQ16 - a;
      end
      if (a > HalfPiQ16) begin
         a    = PiQ16 - a;
         flip = 1'b1;
      end
      x    = a << 12;
      x2   = (x * x) >> 28;
      term = longint'(1) << 28;
      acc  = term;
      for (n = 1; n <= 8; n++) begin
         // all terms are non-negative, so shifts match truncating division
         term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
         acc  = (n % 2 == 1) ? acc - term : acc + term;
      end
      if (acc < 0) begin
         acc = 0;
      end
      q = (acc + 4096) >> 13;
      if (q > 32767) begin
         q = 32767;
      end
      return flip ? -int'(q) : int'(q);
   endfunction

   // advance the scan model by one beam; returns 1 with the event it fires
   function automatic bit predict_brake(input req_type b, output rsp_type ev);
      longint diff;
      longint ang;
      longint idx;
      longint prod;
      longint proj;
      bit     fire;
      fire = 1'b0;
      ev   = '0;
      if (scan_beam < NumBeamsDefault) begin
         if (!scan_braked && b.range_mm != '0 && b.range_mm != NoReturn) begin
            diff = (scan_beam >= CenterBeamDefault) ? scan_beam - CenterBeamDefault
                                                    : CenterBeamDefault - scan_beam;
            ang  = (diff * beam_step_q16) % TwoPiQ16;
            idx  = ang * CosTableDepthDefault / TwoPiQ16;
            if (idx >= CosTableDepthDefault) begin
               idx = CosTableDepthDefault - 1;
            end
            prod = longint'(b.speed_mm_s) * cos_lut[idx];
            // closing only; TTC < limit tested as range*1000 < limit*speed
            if (prod > 0) begin
               proj = prod >>> 15;
               if (proj != 0 &&
                   longint'(b.range_mm) * RangeScale < longint'(brake_thr_ms) * proj) begin
                  ev.beam_index    = BeamIdxW'(scan_beam);
                  ev.closing_speed = ClosingW'(proj);
                  scan_braked      = 1'b1;
                  fire             = 1'b1;
               end
            end
         end
         scan_beam++;
      end
      // last beam is judged first, then the scan restarts
      if (b.last_beam) begin
         scan_beam   = 0;
         scan_braked = 1'b0;
      end
      return fire;
   endfunction

   function automatic req_type make_beam(input int speed, input int range, input bit last);
      req_type b;
      b.speed_mm_s = SpeedW'(speed);
      b.range_mm   = RangeW'(range);
      b.last_beam  = last;
      return b;
   endfunction

   // random beam: speed with its extremes, range weighted toward close hits
   // plus zero, no-return and far values; last flag now and then flipped
   function automatic req_type rand_beam(input bit last);
      int speed;
      int range;
      case ($urandom_range(0, 15))
         0:       speed = -20000;
         1:       speed = 20000;
         2:       speed = 0;
         default: speed = int'($urandom_range(0, 40000)) - 20000;
      endcase
      case ($urandom_range(0, 9))
         0:       range = 0;
         1:       range = int'(NoReturn);
         2:       range = $urandom_range(60000, 65534);
         3, 4, 5: range = $urandom_range(0, 65535);
         default: range = $urandom_range(1, 3000);
      endcase
      return make_beam(speed, range, last ^ ($urandom_range(0, 23) == 0));
   endfunction

   // one beam on req; valid stays up after the beat unless the next one idles
   task automatic send_beam(input req_type b);
      int unsigned gap;
      rsp_type     ev;
      gap = req_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      if (predict_brake(b, ev)) begin
         brake_expect.push_back(ev);
      end
   endtask

   // stop sending, let every predicted event arrive, then let silent beams
   // still in the pipe drain out
   task automatic settle();
      req_valid <= 1'b0;
      while (brake_expect.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // APB transfers: setup, access, then an idle phase
   task automatic write_csr(input logic [CsrAddrW-1:0] addr, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CsrDataW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_check_csr(input logic [CsrAddrW-1:0] addr, input int value);
      logic [CsrDataW-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== CsrDataW'(value)) begin
         $display("%0t: csr 0x%0h read 0x%0h, expected 0x%0h", $time, addr, got, value);
         mismatches++;
      end
   endtask

   // registers change only with the core idle
   task automatic set_config(input int thr, input int step_val);
      settle();
      write_csr(ThrAddr, thr);
      write_csr(StepAddr, step_val);
      brake_thr_ms  = thr;
      beam_step_q16 = step_val;
      read_check_csr(ThrAddr, thr);
      read_check_csr(StepAddr, step_val);
   endtask

   // receiver: random stall before each beat, optional long hold, and the
   // in-order compare of every accepted brake event
   initial begin : brake_sink
      int unsigned hold;
      rsp_type     want;
      rsp_stall <= 1'b0;
      forever begin
         hold = rsp_idle_on ? $urandom_range(0, 8) : 0;
         if (long_hold != 0) begin
            hold      = long_hold;
            long_hold = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && long_hold == 0);
         if (rsp_valid) begin
            if (brake_expect.size() == 0) begin
               $display("%0t: unexpected brake event beam %0d closing %0d", $time,
                        rsp_data.beam_index, rsp_data.closing_speed);
               mismatches++;
            end else begin
               want = brake_expect.pop_front();
               if (rsp_data.beam_index !== want.beam_index) begin
                  $display("%0t: beam_index expected %0d, got %0d", $time,
                           want.beam_index, rsp_data.beam_index);
                  mismatches++;
               end
               if (rsp_data.closing_speed !== want.closing_speed) begin
                  $display("%0t: closing_speed expected %0d, got %0d", $time,
                           want.closing_speed, rsp_data.closing_speed);
                  mismatches++;
               end
            end
         end
      end
   end

   // registers must come out of reset at 250 ms and 286
   task automatic test_reset_values();
      read_check_csr(ThrAddr, int'(ThrReset));
      read_check_csr(StepAddr, int'(StepReset));
   endtask

   // field extremes and each corner of the trigger rule
   task automatic test_special_beams();
      // zero step puts every beam on axis, so only the beam data decides
      set_config(ThrMax, 0);
      send_beam(make_beam(20000, 0, 1'b0));                // zero range
      send_beam(make_beam(20000, int'(NoReturn), 1'b0));   // no return
      send_beam(make_beam(-20000, 100, 1'b0));             // moving away
      send_beam(make_beam(0, 100, 1'b0));                  // standing still
      send_beam(make_beam(1, 100, 1'b0));                  // projection rounds to 0
      send_beam(make_beam(20000, 65534, 1'b0));            // fires at beam 5
      send_beam(make_beam(20000, 1, 1'b0));                // scan already braked
      send_beam(make_beam(20000, 1, 1'b1));                // last beam, still braked
      send_beam(make_beam(20000, 1, 1'b1));                // fires at 0, then restart
      send_beam(make_beam(20000, 1, 1'b1));                // fires at 0 again
      // widest step with the sign of speed flipped
      set_config(ThrMax, StepMax);
      send_beam(make_beam(-20000, 1, 1'b0));
      send_beam(make_beam(20000, 1, 1'b0));
      send_beam(make_beam(-20000, 1, 1'b0));
      send_beam(make_beam(20000, 1, 1'b1));
      // zero threshold never brakes
      set_config(0, int'(StepReset));
      send_beam(make_beam(20000, 1, 1'b0));
      send_beam(make_beam(-20000, 1, 1'b1));
   endtask

   // one scan past NUM_BEAMS: sweeps through the center beam, then the
   // counter saturates and close beams are dropped until the last beam
   task automatic test_full_scan();
      int range;
      set_config(int'(ThrReset), int'(StepReset));
      for (int i = 0; i < NumBeamsDefault + 6; i++) begin
         if (i >= NumBeamsDefault) begin
            send_beam(make_beam(-20000, 1, 1'b0));
         end else begin
            range = ($urandom_range(0, 299) == 0) ? $urandom_range(1, 4000)
                                                 : $urandom_range(0, 65535);
            send_beam(make_beam($urandom_range(0, 20000), range, 1'b0));
         end
      end
      send_beam(make_beam(-20000, 1, 1'b1));
      send_beam(make_beam(20000, 1, 1'b1));
   endtask

   // receiver holds off long while back-to-back braking beams pile up until
   // the core stalls req
   task automatic test_backpressure();
      set_config(ThrMax, 0);
      req_idle_on = 1'b0;
      long_hold   = 300;
      repeat (48) send_beam(make_beam($urandom_range(1000, 20000),
                                      $urandom_range(1, 1000), 1'b1));
      req_idle_on = 1'b1;
   endtask

   // short random scans over several register settings and idle patterns;
   // now and then a longer scan
   task automatic test_random_scans();
      int remaining;
      int len;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       set_config(int'(ThrReset), int'(StepReset));
            1:       set_config(ThrMax, StepMax);
            2:       set_config(0, 0);
            3:       set_config(ThrMax, 0);
            4:       set_config(1, 1);
            default: set_config($urandom_range(0, ThrMax), $urandom_range(0, StepMax));
         endcase
         req_idle_on = (ph & 1) != 0;
         rsp_idle_on = (ph & 2) != 0;
         remaining   = (ph == 2) ? 20 : 40;
         while (remaining > 0) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200)
                                              : $urandom_range(1, 24);
            if (len > remaining) begin
               len = remaining;
            end
            for (int i = 0; i < len; i++) begin
               send_beam(rand_beam(i == len - 1));
            end
            remaining -= len;
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      mismatches    = 0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      long_hold     = 0;
      brake_thr_ms  = int'(ThrReset);
      beam_step_q16 = int'(StepReset);
      scan_beam     = 0;
      scan_braked   = 1'b0;
      for (int k = 0; k < CosTableDepthDefault; k++) begin
         cos_lut[k] = cosine_q15(longint'(k) * TwoPiQ16 / CosTableDepthDefault);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_special_beams();
      test_full_scan();
      test_backpressure();
      test_random_scans();

      settle();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
